@@ hw/rtl/fdnm_pkg.sv @@
// Shared types and constants of the FAT directory name matcher.
`default_nettype none

package fdnm_pkg;

   localparam int NAME_DEPTH     = 261;
   localparam int LANES          = 13;
   localparam int NAME_ROWS      = (NAME_DEPTH + LANES - 1) / LANES;
   localparam int LAST_ROW_LANES = NAME_DEPTH - (NAME_ROWS - 1) * LANES;
   localparam int ROW_W          = $clog2(NAME_ROWS);
   localparam int LANE_W         = $clog2(LANES);
   localparam int POS_W          = 9;
   localparam int SHORT_LEN      = 11;
   localparam int ENTRY_BYTES    = 32;

   // position / 13 as (position * 79) >> 10, exact for positions below 261
   localparam int RECIP_MUL   = 79;
   localparam int RECIP_SHIFT = 10;
   localparam int PROD_W      = POS_W + 7;

   localparam logic [7:0] LFN_ATTR   = 8'h0F;
   localparam int         FIRST_BIT  = 6;
   localparam logic [4:0] SEQ_MASK   = 5'h1F;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_NUL   = 8'h00;

   // byte offsets of the 13 name characters inside a long-name entry
   localparam int LFN_OFFS [LANES] = '{1, 3, 5, 7, 9, 14, 16, 18, 20, 22, 24, 28, 30};

   typedef logic [7:0]                  char_type;
   typedef logic [LANES-1:0][7:0]       row_type;
   typedef logic [ROW_W-1:0]            row_idx_type;
   typedef logic [LANE_W-1:0]           lane_idx_type;
   typedef logic [ENTRY_BYTES-1:0][7:0] entry_type;

   typedef enum logic [1:0] {
      OP_BEGIN = 2'd0,
      OP_LOAD  = 2'd1,
      OP_ENTRY = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      ST_NO_MATCH = 2'd0,
      ST_MATCH    = 2'd1,
      ST_END      = 2'd2,
      ST_DONE     = 2'd3
   } status_type;

   // control of the long-name store
   typedef struct packed {
      logic        fill_en;
      char_type    fill_char;
      logic        wr_en;
      row_idx_type wr_row;
      row_type     wr_data;
      row_idx_type rd_row;
   } lns_ctrl_type;

endpackage

`default_nettype wire

@@ hw/rtl/fdnm_ifs.sv @@
// Request and response channel interfaces of the FAT directory name matcher.
`default_nettype none

interface fdnm_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [63:0] entry_bytes_0_7;
   logic [63:0] entry_bytes_8_15;
   logic [63:0] entry_bytes_16_23;
   logic [63:0] entry_bytes_24_31;
   logic [8:0]  target_position;
   logic [7:0]  target_char;

   modport source (
      output valid, opcode, entry_bytes_0_7, entry_bytes_8_15, entry_bytes_16_23,
             entry_bytes_24_31, target_position, target_char,
      input  ready
   );
   modport sink (
      input  valid, opcode, entry_bytes_0_7, entry_bytes_8_15, entry_bytes_16_23,
             entry_bytes_24_31, target_position, target_char,
      output ready
   );
endinterface

interface fdnm_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] first_cluster;
   logic [31:0] file_size;
   logic [7:0]  entry_attribute;

   modport source (
      output valid, status, first_cluster, file_size, entry_attribute,
      input  ready
   );
   modport sink (
      input  valid, status, first_cluster, file_size, entry_attribute,
      output ready
   );
endinterface

`default_nettype wire

@@ hw/rtl/fat_directory_name_matcher_top.sv @@
// Top level of the FAT directory name matcher: sequencer, target store and result register.
`default_nettype none

// Takes one transaction at a time. Begin search, target loads and long-name entries
// go from dispatch straight to the result. A short entry with no long name pending
// reads target row 0 once. A short entry after a long name walks the long-name store,
// which holds 13 characters per row in 21 rows behind one read port: a downward scan
// for trailing spaces, a read-modify-write of the terminator and an upward compare
// against the target. The result register lets the consumer stall without losing the
// result; the next transaction is taken once that result is loaded. There is no clearing
// pass: per-row valid bits give the reset value at once.
module fat_directory_name_matcher_top #(
   parameter int MAX_NAME_SLOTS = 20
) (
   input  wire logic       clock,
   input  wire logic       reset,
   fdnm_req_if.sink        req_ch,
   fdnm_rsp_if.source      rsp_ch
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_TRIM,
      S_TERM_RD,
      S_TERM_WR,
      S_CMP,
      S_RESP
   } state_type;

   localparam fdnm_pkg::row_idx_type LAST_ROW  =
      fdnm_pkg::row_idx_type'(fdnm_pkg::NAME_ROWS - 1);
   localparam fdnm_pkg::row_idx_type SCAN_TOP  =
      fdnm_pkg::row_idx_type'(fdnm_pkg::NAME_ROWS - 2);
   localparam fdnm_pkg::lane_idx_type TOP_LANE =
      fdnm_pkg::lane_idx_type'(fdnm_pkg::LANES - 1);

   state_type                  state_ff;
   logic [1:0]                 op_ff;
   fdnm_pkg::entry_type        ent_ff;
   logic [fdnm_pkg::POS_W-1:0] pos_ff;
   fdnm_pkg::char_type         chr_ff;
   logic                       pending_ff;
   fdnm_pkg::row_idx_type      iss_ff;
   logic                       iss_on_ff;
   fdnm_pkg::row_idx_type      chk_ff;
   logic                       chk_dv_ff;
   fdnm_pkg::row_idx_type      term_row_ff;
   fdnm_pkg::lane_idx_type     term_lane_ff;
   fdnm_pkg::status_type       result_ff;
   logic                       rsp_valid_ff;
   fdnm_pkg::status_type       rsp_status_ff;
   logic [31:0]                rsp_cluster_ff;
   logic [31:0]                rsp_size_ff;
   logic [7:0]                 rsp_attr_ff;

   fdnm_pkg::entry_type        req_entry;
   fdnm_pkg::lns_ctrl_type     lns_ctrl;
   fdnm_pkg::row_type          lns_rd;

   // target store
   fdnm_pkg::row_type          tgt_mem [fdnm_pkg::NAME_ROWS];
   fdnm_pkg::row_type          tgt_rd_ff;
   logic                       tgt_wr_en;
   fdnm_pkg::row_idx_type      tgt_wr_row;
   fdnm_pkg::lane_idx_type     tgt_wr_lane;
   fdnm_pkg::row_idx_type      tgt_rd_row;

   logic [fdnm_pkg::PROD_W-1:0] pos_prod;
   logic [fdnm_pkg::POS_W-1:0]  lane_full;

   logic [4:0]                 seq;
   logic [4:0]                 slot;
   logic                       slot_ok;
   fdnm_pkg::row_type          lfn_row;

   logic                       trim_any;
   fdnm_pkg::lane_idx_type     trim_hi;
   fdnm_pkg::row_idx_type      trim_row;
   fdnm_pkg::lane_idx_type     trim_lane;
   fdnm_pkg::row_type          term_data;

   logic [fdnm_pkg::LANES-1:0]     long_dec;
   logic                           long_any;
   logic                           long_res;
   logic [fdnm_pkg::SHORT_LEN-1:0] short_dec;
   logic                           short_hit;

   logic                       rsp_free;

   assign req_entry = {req_ch.entry_bytes_24_31, req_ch.entry_bytes_16_23,
                       req_ch.entry_bytes_8_15, req_ch.entry_bytes_0_7};
   assign req_ch.ready = (state_ff == S_IDLE);
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;

   fdnm_name_store u_name_store (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (lns_ctrl),
      .rd_data (lns_rd)
   );

   always_ff @(posedge clock) begin
      if (tgt_wr_en) begin
         tgt_mem[tgt_wr_row][tgt_wr_lane] <= chr_ff;
      end
      tgt_rd_ff <= tgt_mem[tgt_rd_row];
   end

   // target position to row and lane
   always_comb begin
      pos_prod    = fdnm_pkg::PROD_W'(pos_ff) * fdnm_pkg::PROD_W'(fdnm_pkg::RECIP_MUL);
      tgt_wr_row  = pos_prod[fdnm_pkg::RECIP_SHIFT +: fdnm_pkg::ROW_W];
      lane_full   = pos_ff - fdnm_pkg::POS_W'(tgt_wr_row * fdnm_pkg::LANES);
      tgt_wr_lane = lane_full[fdnm_pkg::LANE_W-1:0];
   end

   // long-name entry fields
   always_comb begin
      seq     = ent_ff[0][4:0] & fdnm_pkg::SEQ_MASK;
      slot    = seq - 5'd1;
      slot_ok = (seq != 5'd0) && (int'(slot) < MAX_NAME_SLOTS) &&
                (int'(slot) < fdnm_pkg::NAME_ROWS - 1);
      for (int c = 0; c < fdnm_pkg::LANES; c++) begin
         lfn_row[c] = ent_ff[fdnm_pkg::LFN_OFFS[c]];
      end
   end

   // trailing-space scan of one row; the terminator goes one past the last non-space
   always_comb begin
      trim_any = 1'b0;
      trim_hi  = '0;
      for (int i = 0; i < fdnm_pkg::LANES; i++) begin
         if (lns_rd[i] != fdnm_pkg::CHAR_SPACE) begin
            trim_any = 1'b1;
            trim_hi  = fdnm_pkg::LANE_W'(i);
         end
      end
      if (trim_hi == TOP_LANE) begin
         trim_row  = chk_ff + fdnm_pkg::ROW_W'(1);
         trim_lane = '0;
      end else begin
         trim_row  = chk_ff;
         trim_lane = trim_hi + fdnm_pkg::LANE_W'(1);
      end
      term_data = lns_rd;
      term_data[term_lane_ff] = fdnm_pkg::CHAR_NUL;
   end

   // name compares: the first lane that differs or ends the name decides
   always_comb begin
      long_dec = '0;
      for (int i = 0; i < fdnm_pkg::LANES; i++) begin
         long_dec[i] = ((chk_ff != LAST_ROW) || (i < fdnm_pkg::LAST_ROW_LANES)) &&
                       ((lns_rd[i] != tgt_rd_ff[i]) || (lns_rd[i] == fdnm_pkg::CHAR_NUL));
      end
      long_any = |long_dec;
      long_res = 1'b1;
      for (int i = fdnm_pkg::LANES - 1; i >= 0; i--) begin
         if (long_dec[i]) begin
            long_res = (lns_rd[i] == tgt_rd_ff[i]);
         end
      end
      for (int i = 0; i < fdnm_pkg::SHORT_LEN; i++) begin
         short_dec[i] = (ent_ff[i] != tgt_rd_ff[i]) || (ent_ff[i] == fdnm_pkg::CHAR_NUL);
      end
      short_hit = 1'b1;
      for (int i = fdnm_pkg::SHORT_LEN - 1; i >= 0; i--) begin
         if (short_dec[i]) begin
            short_hit = (ent_ff[i] == tgt_rd_ff[i]);
         end
      end
   end

   // memory control
   always_comb begin
      lns_ctrl   = '0;
      tgt_wr_en  = 1'b0;
      tgt_rd_row = iss_ff;
      case (state_ff)
         S_DISPATCH: begin
            case (op_ff)
               fdnm_pkg::OP_BEGIN: begin
                  lns_ctrl.fill_en   = 1'b1;
                  lns_ctrl.fill_char = fdnm_pkg::CHAR_NUL;
               end
               fdnm_pkg::OP_LOAD: begin
                  tgt_wr_en = (pos_ff < fdnm_pkg::POS_W'(fdnm_pkg::NAME_DEPTH));
               end
               fdnm_pkg::OP_ENTRY: begin
                  if ((ent_ff[0] != fdnm_pkg::CHAR_NUL) && (ent_ff[11] == fdnm_pkg::LFN_ATTR)) begin
                     lns_ctrl.fill_en   = ent_ff[0][fdnm_pkg::FIRST_BIT];
                     lns_ctrl.fill_char = fdnm_pkg::CHAR_SPACE;
                     lns_ctrl.wr_en     = slot_ok;
                     lns_ctrl.wr_row    = slot;
                     lns_ctrl.wr_data   = lfn_row;
                  end
               end
               default: begin
               end
            endcase
         end
         S_TRIM:    lns_ctrl.rd_row = iss_ff;
         S_TERM_RD: lns_ctrl.rd_row = term_row_ff;
         S_TERM_WR: begin
            lns_ctrl.wr_en   = 1'b1;
            lns_ctrl.wr_row  = term_row_ff;
            lns_ctrl.wr_data = term_data;
         end
         S_CMP:     lns_ctrl.rd_row = iss_ff;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         iss_on_ff    <= 1'b0;
         chk_dv_ff    <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_ch.valid) begin
                  op_ff    <= req_ch.opcode;
                  ent_ff   <= req_entry;
                  pos_ff   <= req_ch.target_position;
                  chr_ff   <= req_ch.target_char;
                  state_ff <= S_DISPATCH;
               end
            end
            S_DISPATCH: begin
               result_ff <= fdnm_pkg::ST_DONE;
               state_ff  <= S_RESP;
               case (op_ff)
                  fdnm_pkg::OP_BEGIN: pending_ff <= 1'b0;
                  fdnm_pkg::OP_ENTRY: begin
                     if (ent_ff[0] == fdnm_pkg::CHAR_NUL) begin
                        result_ff <= fdnm_pkg::ST_END;
                     end else if (ent_ff[11] == fdnm_pkg::LFN_ATTR) begin
                        result_ff  <= fdnm_pkg::ST_NO_MATCH;
                        pending_ff <= 1'b1;
                     end else begin
                        chk_dv_ff <= 1'b0;
                        iss_on_ff <= 1'b1;
                        if (pending_ff) begin
                           iss_ff   <= SCAN_TOP;
                           state_ff <= S_TRIM;
                        end else begin
                           iss_ff   <= '0;
                           state_ff <= S_CMP;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
            S_TRIM: begin
               // reads issue one row ahead of the check, downward
               chk_dv_ff <= iss_on_ff;
               if (iss_on_ff) begin
                  chk_ff <= iss_ff;
                  if (iss_ff == '0) begin
                     iss_on_ff <= 1'b0;
                  end else begin
                     iss_ff <= iss_ff - fdnm_pkg::ROW_W'(1);
                  end
               end
               if (chk_dv_ff) begin
                  if (trim_any) begin
                     term_row_ff  <= trim_row;
                     term_lane_ff <= trim_lane;
                     state_ff     <= S_TERM_RD;
                  end else if (chk_ff == '0) begin
                     term_row_ff  <= '0;
                     term_lane_ff <= '0;
                     state_ff     <= S_TERM_RD;
                  end
               end
            end
            S_TERM_RD: state_ff <= S_TERM_WR;
            S_TERM_WR: begin
               iss_ff    <= '0;
               iss_on_ff <= 1'b1;
               chk_dv_ff <= 1'b0;
               state_ff  <= S_CMP;
            end
            S_CMP: begin
               // reads issue one row ahead of the check, upward
               chk_dv_ff <= iss_on_ff;
               if (iss_on_ff) begin
                  chk_ff <= iss_ff;
                  if (iss_ff == LAST_ROW) begin
                     iss_on_ff <= 1'b0;
                  end else begin
                     iss_ff <= iss_ff + fdnm_pkg::ROW_W'(1);
                  end
               end
               if (chk_dv_ff) begin
                  if ((chk_ff == '0) && (short_hit || !pending_ff)) begin
                     result_ff  <= short_hit ? fdnm_pkg::ST_MATCH : fdnm_pkg::ST_NO_MATCH;
                     pending_ff <= 1'b0;
                     state_ff   <= S_RESP;
                  end else if (long_any) begin
                     result_ff  <= long_res ? fdnm_pkg::ST_MATCH : fdnm_pkg::ST_NO_MATCH;
                     pending_ff <= 1'b0;
                     state_ff   <= S_RESP;
                  end else if (chk_ff == LAST_ROW) begin
                     result_ff  <= fdnm_pkg::ST_MATCH;
                     pending_ff <= 1'b0;
                     state_ff   <= S_RESP;
                  end
               end
            end
            S_RESP: begin
               if (rsp_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= result_ff;
                  if (result_ff == fdnm_pkg::ST_MATCH) begin
                     rsp_cluster_ff <= {ent_ff[21], ent_ff[20], ent_ff[27], ent_ff[26]};
                     rsp_size_ff    <= {ent_ff[31], ent_ff[30], ent_ff[29], ent_ff[28]};
                     rsp_attr_ff    <= ent_ff[11];
                  end else begin
                     rsp_cluster_ff <= '0;
                     rsp_size_ff    <= '0;
                     rsp_attr_ff    <= '0;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.status          = rsp_status_ff;
   assign rsp_ch.first_cluster   = rsp_cluster_ff;
   assign rsp_ch.file_size       = rsp_size_ff;
   assign rsp_ch.entry_attribute = rsp_attr_ff;

endmodule

`default_nettype wire

@@ hw/rtl/fdnm_name_store.sv @@
// Long-name store: row-wide memory with per-row valid bits and a common fill character.
`default_nettype none

module fdnm_name_store (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire fdnm_pkg::lns_ctrl_type ctrl,
   output fdnm_pkg::row_type          rd_data
);

   fdnm_pkg::row_type          mem [fdnm_pkg::NAME_ROWS];
   fdnm_pkg::row_type          rd_raw_ff;
   logic                       rd_valid_ff;
   logic [fdnm_pkg::NAME_ROWS-1:0] row_valid_ff;
   fdnm_pkg::char_type         fill_ff;

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem[ctrl.wr_row] <= ctrl.wr_data;
      end
      rd_raw_ff <= mem[ctrl.rd_row];
   end

   // a row not written since the last fill reads as the fill character
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         fill_ff      <= fdnm_pkg::CHAR_NUL;
         rd_valid_ff  <= 1'b0;
      end else begin
         if (ctrl.fill_en) begin
            row_valid_ff <= '0;
            fill_ff      <= ctrl.fill_char;
         end
         if (ctrl.wr_en) begin
            row_valid_ff[ctrl.wr_row] <= 1'b1;
         end
         rd_valid_ff <= row_valid_ff[ctrl.rd_row];
      end
   end

   assign rd_data = rd_valid_ff ? rd_raw_ff : {fdnm_pkg::LANES{fill_ff}};

endmodule

`default_nettype wire

@@ hw/rtl/fdnm_checker.sv @@
// Port-level checks of the FAT directory name matcher and their binding to the top level.
`default_nettype none

module fdnm_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [1:0]  rsp_status,
   input wire logic [31:0] rsp_first_cluster,
   input wire logic [31:0] rsp_file_size,
   input wire logic [7:0]  rsp_entry_attribute
);

   // one transaction at a time: the block is busy right after taking one
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("req ready high right after a transaction");

   // a result appears only as the block returns to waiting for work
   a_ready_with_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_ready)
      else $error("new result while the block is still busy");

   a_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != fdnm_pkg::ST_MATCH)) |->
      ((rsp_first_cluster == 32'd0) && (rsp_file_size == 32'd0) &&
       (rsp_entry_attribute == 8'd0)))
      else $error("entry fields set on a result that is not a match");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
      (rsp_valid && $stable(rsp_status) && $stable(rsp_first_cluster) &&
       $stable(rsp_file_size) && $stable(rsp_entry_attribute)))
      else $error("stalled result changed or dropped");

endmodule

bind fat_directory_name_matcher_top fdnm_checker u_fdnm_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_ch.valid),
   .req_ready           (req_ch.ready),
   .rsp_valid           (rsp_ch.valid),
   .rsp_ready           (rsp_ch.ready),
   .rsp_status          (rsp_ch.status),
   .rsp_first_cluster   (rsp_ch.first_cluster),
   .rsp_file_size       (rsp_ch.file_size),
   .rsp_entry_attribute (rsp_ch.entry_attribute)
);

`default_nettype wire
